// File: sv/dna_pkg.sv
package dna_pkg;

    localparam int FracBitsDef = 16;
    localparam int WordBitsDef = 32;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;

    typedef struct packed {
        logic valid;
        logic use_div;
        logic neg_r;
        logic neg_d;
    } t_div_ctl;

endpackage

// File: sv/dna_divstep.sv
module dna_divstep #(
    parameter int W  = dna_pkg::WordBitsDef,
    parameter int SW = 2 * dna_pkg::WordBitsDef + 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  dna_pkg::t_div_ctl i_ctl,
    input  logic [W-1:0]      i_r_rem,
    input  logic [W-1:0]      i_r_low,
    input  logic [W-1:0]      i_r_den,
    input  logic [W-1:0]      i_r_q,
    input  logic [2*W-1:0]    i_d_rem,
    input  logic [W-1:0]      i_d_low,
    input  logic [2*W-1:0]    i_d_den,
    input  logic [W-1:0]      i_d_q,
    input  logic [SW-1:0]     i_side,
    output dna_pkg::t_div_ctl o_ctl,
    output logic [W-1:0]      o_r_rem,
    output logic [W-1:0]      o_r_low,
    output logic [W-1:0]      o_r_den,
    output logic [W-1:0]      o_r_q,
    output logic [2*W-1:0]    o_d_rem,
    output logic [W-1:0]      o_d_low,
    output logic [2*W-1:0]    o_d_den,
    output logic [W-1:0]      o_d_q,
    output logic [SW-1:0]     o_side
);

    localparam int P = 2 * W;

    dna_pkg::t_div_ctl r_ctl;
    logic [W-1:0]      r_r_rem, r_r_low, r_r_den, r_r_q;
    logic [P-1:0]      r_d_rem, r_d_den;
    logic [W-1:0]      r_d_low, r_d_q;
    logic [SW-1:0]     r_side;

    logic [W:0]   w_r_sh;
    logic         w_r_ge;
    logic [W:0]   w_r_diff;
    logic [W-1:0] n_r_rem;
    logic [P:0]   w_d_sh;
    logic         w_d_ge;
    logic [P:0]   w_d_diff;
    logic [P-1:0] n_d_rem;

    always_comb begin
        w_r_sh   = {i_r_rem, i_r_low[W-1]};
        w_r_ge   = w_r_sh >= {1'b0, i_r_den};
        w_r_diff = w_r_sh - {1'b0, i_r_den};
        n_r_rem  = w_r_ge ? w_r_diff[W-1:0] : w_r_sh[W-1:0];
        w_d_sh   = {i_d_rem, i_d_low[W-1]};
        w_d_ge   = w_d_sh >= {1'b0, i_d_den};
        w_d_diff = w_d_sh - {1'b0, i_d_den};
        n_d_rem  = w_d_ge ? w_d_diff[P-1:0] : w_d_sh[P-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_r_rem <= n_r_rem;
            r_r_low <= {i_r_low[W-2:0], 1'b0};
            r_r_den <= i_r_den;
            r_r_q   <= {i_r_q[W-2:0], w_r_ge};
            r_d_rem <= n_d_rem;
            r_d_low <= {i_d_low[W-2:0], 1'b0};
            r_d_den <= i_d_den;
            r_d_q   <= {i_d_q[W-2:0], w_d_ge};
            r_side  <= i_side;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_r_rem = r_r_rem;
    assign o_r_low = r_r_low;
    assign o_r_den = r_r_den;
    assign o_r_q   = r_r_q;
    assign o_d_rem = r_d_rem;
    assign o_d_low = r_d_low;
    assign o_d_den = r_d_den;
    assign o_d_q   = r_d_q;
    assign o_side  = r_side;

endmodule

// File: sv/dual_number_alu.sv
// Channel  Valid        Ready        Payload
// request  i_req_valid  o_req_ready  i_req_type, i_a_real, i_a_dual, i_b_real, i_b_dual
// result   o_res_valid  i_res_ready  o_res_real, o_res_dual, o_div_zero, o_overflow
//
// One request enters per cycle while o_req_ready is high.
// Both dividers produce one quotient bit per stage.
// Reset clears all stage valid bits; payload registers are not reset.
// A stalled result freezes the whole pipeline; o_req_ready drops with it.
module dual_number_alu #(
    parameter int FRAC_BITS = dna_pkg::FracBitsDef,
    parameter int WORD_BITS = dna_pkg::WordBitsDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [2:0]                  i_req_type,
    input  logic signed [WORD_BITS-1:0] i_a_real,
    input  logic signed [WORD_BITS-1:0] i_a_dual,
    input  logic signed [WORD_BITS-1:0] i_b_real,
    input  logic signed [WORD_BITS-1:0] i_b_dual,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic signed [WORD_BITS-1:0] o_res_real,
    output logic signed [WORD_BITS-1:0] o_res_dual,
    output logic                        o_div_zero,
    output logic                        o_overflow
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int P   = 2 * W;
    localparam int SW  = 2 * W + 4;
    localparam int NW  = W + F;
    localparam int N2W = P + 1 + F;
    localparam int CW  = N2W + P;

    localparam logic [W-1:0] MaxVal  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MinVal  = {1'b1, {(W-1){1'b0}}};
    localparam logic [P:0]   HalfMag = (P+1)'(1) << (W - 1);
    localparam logic [P:0]   OneMag  = (P+1)'(1) << F;

    function automatic logic [W:0] f_sat_mag(input logic neg, input logic [P:0] mag);
        logic [W:0] res;
        if (!neg) begin
            res = (mag > (HalfMag - 1'b1)) ? {1'b1, MaxVal} : {1'b0, mag[W-1:0]};
        end else begin
            res = (mag > HalfMag) ? {1'b1, MinVal} : {1'b0, W'(~mag[W-1:0] + 1'b1)};
        end
        return res;
    endfunction

    function automatic logic [W:0] f_sat_sum(input logic [W:0] v);
        logic [W:0] res;
        if (v[W] != v[W-1]) begin
            res = {1'b1, (v[W] ? MinVal : MaxVal)};
        end else begin
            res = {1'b0, v[W-1:0]};
        end
        return res;
    endfunction

    function automatic logic [W-1:0] f_abs(input logic [W-1:0] x);
        return x[W-1] ? W'(~x + 1'b1) : x;
    endfunction

    logic w_adv;
    assign w_adv       = !o_res_valid || i_res_ready;
    assign o_req_ready = w_adv;

    // stage 1: magnitudes and linear ops
    logic         r1_v, r1_bz, r1_nar, r1_nad, r1_nbr, r1_nbd;
    logic [2:0]   r1_op;
    logic [W:0]   r1_sum_r, r1_sum_d, n1_sum_r, n1_sum_d;
    logic [W-1:0] r1_mar, r1_mad, r1_mbr, r1_mbd;
    logic [W:0]   w_ar_x, w_ad_x, w_br_x, w_bd_x;

    always_comb begin
        w_ar_x = {i_a_real[W-1], i_a_real};
        w_ad_x = {i_a_dual[W-1], i_a_dual};
        w_br_x = {i_b_real[W-1], i_b_real};
        w_bd_x = {i_b_dual[W-1], i_b_dual};
        unique case (i_req_type)
            dna_pkg::OP_ADD: begin
                n1_sum_r = w_ar_x + w_br_x;
                n1_sum_d = w_ad_x + w_bd_x;
            end
            dna_pkg::OP_SUB: begin
                n1_sum_r = w_ar_x - w_br_x;
                n1_sum_d = w_ad_x - w_bd_x;
            end
            dna_pkg::OP_NEG: begin
                n1_sum_r = (W+1)'(0) - w_ar_x;
                n1_sum_d = (W+1)'(0) - w_ad_x;
            end
            default: begin
                n1_sum_r = '0;
                n1_sum_d = '0;
            end
        endcase
    end

    // stage 2: products
    logic         r2_v, r2_bz, r2_nr, r2_nadbr, r2_narbd;
    logic [2:0]   r2_op;
    logic [W:0]   r2_sum_r, r2_sum_d;
    logic [W-1:0] r2_mar, r2_mbr;
    logic [P-1:0] r2_prr, r2_padbr, r2_parbd, r2_pbb;

    // stage 3: signed cross products
    logic         r3_v, r3_bz, r3_nr;
    logic [2:0]   r3_op;
    logic [W:0]   r3_sum_r, r3_sum_d;
    logic [W-1:0] r3_mar, r3_mbr;
    logic [P-1:0] r3_prr, r3_pbb;
    logic [P:0]   r3_s1, r3_s2;

    // stage 4: dual numerator
    logic         r4_v, r4_bz, r4_nr;
    logic [2:0]   r4_op;
    logic [W:0]   r4_sum_r, r4_sum_d;
    logic [W-1:0] r4_mar, r4_mbr;
    logic [P-1:0] r4_prr, r4_pbb;
    logic [P+1:0] r4_ds;

    // stage 5: dual magnitude
    logic         r5_v, r5_bz, r5_nr, r5_dneg;
    logic [2:0]   r5_op;
    logic [W:0]   r5_sum_r, r5_sum_d;
    logic [W-1:0] r5_mar, r5_mbr;
    logic [P-1:0] r5_prr, r5_pbb;
    logic [P:0]   r5_dmag;
    logic [P+1:0] w4_neg;

    assign w4_neg = (P+2)'(~r4_ds + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_req_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_op    <= i_req_type;
            r1_bz    <= (i_b_real == '0);
            r1_sum_r <= n1_sum_r;
            r1_sum_d <= n1_sum_d;
            r1_mar   <= f_abs(i_a_real);
            r1_mad   <= f_abs(i_a_dual);
            r1_mbr   <= f_abs(i_b_real);
            r1_mbd   <= f_abs(i_b_dual);
            r1_nar   <= i_a_real[W-1];
            r1_nad   <= i_a_dual[W-1];
            r1_nbr   <= i_b_real[W-1];
            r1_nbd   <= i_b_dual[W-1];

            r2_op    <= r1_op;
            r2_bz    <= r1_bz;
            r2_sum_r <= r1_sum_r;
            r2_sum_d <= r1_sum_d;
            r2_mar   <= r1_mar;
            r2_mbr   <= r1_mbr;
            r2_nr    <= r1_nar ^ r1_nbr;
            r2_nadbr <= r1_nad ^ r1_nbr;
            r2_narbd <= r1_nar ^ r1_nbd;
            r2_prr   <= P'(r1_mar) * P'(r1_mbr);
            r2_padbr <= P'(r1_mad) * P'(r1_mbr);
            r2_parbd <= P'(r1_mar) * P'(r1_mbd);
            r2_pbb   <= P'(r1_mbr) * P'(r1_mbr);

            r3_op    <= r2_op;
            r3_bz    <= r2_bz;
            r3_sum_r <= r2_sum_r;
            r3_sum_d <= r2_sum_d;
            r3_mar   <= r2_mar;
            r3_mbr   <= r2_mbr;
            r3_nr    <= r2_nr;
            r3_prr   <= r2_prr;
            r3_pbb   <= r2_pbb;
            r3_s1    <= r2_nadbr ? (P+1)'(0) - {1'b0, r2_padbr} : {1'b0, r2_padbr};
            r3_s2    <= r2_narbd ? (P+1)'(0) - {1'b0, r2_parbd} : {1'b0, r2_parbd};

            r4_op    <= r3_op;
            r4_bz    <= r3_bz;
            r4_sum_r <= r3_sum_r;
            r4_sum_d <= r3_sum_d;
            r4_mar   <= r3_mar;
            r4_mbr   <= r3_mbr;
            r4_nr    <= r3_nr;
            r4_prr   <= r3_prr;
            r4_pbb   <= r3_pbb;
            r4_ds    <= (r3_op == dna_pkg::OP_DIV) ?
                        {r3_s1[P], r3_s1} - {r3_s2[P], r3_s2} :
                        {r3_s1[P], r3_s1} + {r3_s2[P], r3_s2};

            r5_op    <= r4_op;
            r5_bz    <= r4_bz;
            r5_sum_r <= r4_sum_r;
            r5_sum_d <= r4_sum_d;
            r5_mar   <= r4_mar;
            r5_mbr   <= r4_mbr;
            r5_nr    <= r4_nr;
            r5_prr   <= r4_prr;
            r5_pbb   <= r4_pbb;
            r5_dneg  <= r4_ds[P+1];
            r5_dmag  <= r4_ds[P+1] ? w4_neg[P:0] : r4_ds[P:0];
        end
    end

    // stage 6: finish non-divide results, set up dividers
    logic [W:0]     n6_sr, n6_sd;
    logic           n6_dz;
    logic [NW-1:0]  w6_n, w6_hi;
    logic           w6_r_ovf;
    logic [N2W-1:0] w6_n2;
    logic [CW-1:0]  w6_h2;
    logic           w6_d_ovf;

    always_comb begin
        n6_dz = 1'b0;
        unique case (r5_op)
            dna_pkg::OP_ADD, dna_pkg::OP_SUB, dna_pkg::OP_NEG: begin
                n6_sr = f_sat_sum(r5_sum_r);
                n6_sd = f_sat_sum(r5_sum_d);
            end
            dna_pkg::OP_MUL: begin
                n6_sr = f_sat_mag(r5_nr, (P+1)'(r5_prr >> F));
                n6_sd = f_sat_mag(r5_dneg, r5_dmag >> F);
            end
            dna_pkg::OP_DIV: begin
                n6_sr = '0;
                n6_sd = r5_bz ? f_sat_mag(1'b0, OneMag) : '0;
                n6_dz = r5_bz;
            end
            default: begin
                n6_sr = '0;
                n6_sd = '0;
            end
        endcase
        w6_n     = {r5_mar, {F{1'b0}}};
        w6_hi    = w6_n >> W;
        w6_r_ovf = w6_hi >= NW'(r5_mbr);
        w6_n2    = {r5_dmag, {F{1'b0}}};
        w6_h2    = CW'(w6_n2 >> W);
        w6_d_ovf = w6_h2 >= CW'(r5_pbb);
    end

    dna_pkg::t_div_ctl r6_ctl;
    logic [W-1:0]      r6_r_rem, r6_r_low, r6_r_den;
    logic [P-1:0]      r6_d_rem, r6_d_den;
    logic [W-1:0]      r6_d_low;
    logic [SW-1:0]     r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_ctl <= '0;
        end else if (w_adv) begin
            r6_ctl.valid   <= r5_v;
            r6_ctl.use_div <= (r5_op == dna_pkg::OP_DIV) && !r5_bz;
            r6_ctl.neg_r   <= r5_nr;
            r6_ctl.neg_d   <= r5_dneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_r_rem <= w6_r_ovf ? '0 : w6_hi[W-1:0];
            r6_r_low <= w6_n[W-1:0];
            r6_r_den <= r5_mbr;
            r6_d_rem <= w6_d_ovf ? '0 : w6_h2[P-1:0];
            r6_d_low <= w6_n2[W-1:0];
            r6_d_den <= r5_pbb;
            r6_side  <= {n6_sr[W-1:0], n6_sd[W-1:0], n6_dz, n6_sr[W] | n6_sd[W],
                         w6_r_ovf, w6_d_ovf};
        end
    end

    // divider stages
    dna_pkg::t_div_ctl w_ctl [0:W];
    logic [W-1:0]      w_rrem [0:W];
    logic [W-1:0]      w_rlow [0:W];
    logic [W-1:0]      w_rden [0:W];
    logic [W-1:0]      w_rq   [0:W];
    logic [P-1:0]      w_drem [0:W];
    logic [W-1:0]      w_dlow [0:W];
    logic [P-1:0]      w_dden [0:W];
    logic [W-1:0]      w_dq   [0:W];
    logic [SW-1:0]     w_side [0:W];

    assign w_ctl[0]  = r6_ctl;
    assign w_rrem[0] = r6_r_rem;
    assign w_rlow[0] = r6_r_low;
    assign w_rden[0] = r6_r_den;
    assign w_rq[0]   = '0;
    assign w_drem[0] = r6_d_rem;
    assign w_dlow[0] = r6_d_low;
    assign w_dden[0] = r6_d_den;
    assign w_dq[0]   = '0;
    assign w_side[0] = r6_side;

    for (genvar g = 0; g < W; g++) begin : g_div
        dna_divstep #(
            .W  (W),
            .SW (SW)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctl   (w_ctl[g]),
            .i_r_rem (w_rrem[g]),
            .i_r_low (w_rlow[g]),
            .i_r_den (w_rden[g]),
            .i_r_q   (w_rq[g]),
            .i_d_rem (w_drem[g]),
            .i_d_low (w_dlow[g]),
            .i_d_den (w_dden[g]),
            .i_d_q   (w_dq[g]),
            .i_side  (w_side[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_r_rem (w_rrem[g+1]),
            .o_r_low (w_rlow[g+1]),
            .o_r_den (w_rden[g+1]),
            .o_r_q   (w_rq[g+1]),
            .o_d_rem (w_drem[g+1]),
            .o_d_low (w_dlow[g+1]),
            .o_d_den (w_dden[g+1]),
            .o_d_q   (w_dq[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // output stage
    logic [W:0]   n_out_r, n_out_d;
    logic         n_out_dz, n_out_ovf;
    logic [SW-1:0] w_last;
    logic          r_out_v, r_out_dz, r_out_ovf;
    logic [W-1:0]  r_out_real, r_out_dual;

    assign w_last = w_side[W];

    always_comb begin
        if (w_ctl[W].use_div) begin
            n_out_r   = f_sat_mag(w_ctl[W].neg_r, (P+1)'({w_last[1], w_rq[W]}));
            n_out_d   = f_sat_mag(w_ctl[W].neg_d, (P+1)'({w_last[0], w_dq[W]}));
            n_out_dz  = 1'b0;
            n_out_ovf = n_out_r[W] | n_out_d[W];
        end else begin
            n_out_r   = {1'b0, w_last[SW-1 -: W]};
            n_out_d   = {1'b0, w_last[SW-1-W -: W]};
            n_out_dz  = w_last[3];
            n_out_ovf = w_last[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= w_ctl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_real <= n_out_r[W-1:0];
            r_out_dual <= n_out_d[W-1:0];
            r_out_dz   <= n_out_dz;
            r_out_ovf  <= n_out_ovf;
        end
    end

    assign o_res_valid = r_out_v;
    assign o_res_real  = r_out_real;
    assign o_res_dual  = r_out_dual;
    assign o_div_zero  = r_out_dz;
    assign o_overflow  = r_out_ovf;

    a_dz_real_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_div_zero |-> r_out_real == '0)
        else $error("divide by zero with nonzero real part");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_overflow |->
            (r_out_real == MaxVal || r_out_real == MinVal ||
             r_out_dual == MaxVal || r_out_dual == MinVal))
        else $error("overflow without saturated part");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid && !w_ctl[W].valid)
        else $error("pipeline not empty after reset");

endmodule
